>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the support side estimator checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define SSEST_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define SSEST_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SSEST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/ssest_pkg.sv
// ----------------------------------------------------------------------------
// ssest_pkg
// Widths, register codes and shared structs of the support side estimator.
// ----------------------------------------------------------------------------
package ssest_pkg;

  // Sensor array and field widths.
  localparam int SensorCount = 8;
  localparam int IdxW        = $clog2(SensorCount);
  localparam int ReadW       = 16;
  localparam int FracW       = 16;
  localparam int WeightW     = 15;
  localparam int QuotW       = 16;

  // Sum of all Q1.15 fractions, and the weighted sum that grows from it.
  localparam int TotalW = $clog2(SensorCount * 32768 + 1);
  localparam int RemW   = TotalW + 1;
  localparam int ProdW  = FracW + WeightW;
  localparam int AccW   = TotalW + WeightW;
  localparam int MagW   = AccW - 1;

  // Configuration port.
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [ReadW-1:0]   ClampReset  = 16'hFFFF;
  localparam logic [ReadW-1:0]   PeakReset   = 16'd410;
  localparam logic [WeightW-1:0] WeightReset = 15'd4096;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CLAMP      = 2'd0,
    REG_PEAK_START = 2'd1,
    REG_OUTER      = 2'd2,
    REG_INNER      = 2'd3
  } cfg_reg_t;

  // Request to the serial divider.
  typedef struct packed {
    logic              start;
    logic [TotalW-1:0] rem_init;
    logic [QuotW-1:0]  low_bits;
    logic [TotalW-1:0] divisor;
  } div_req_t;

  // One quotient bit per cycle, most significant first.
  typedef struct packed {
    logic q_valid;
    logic q_bit;
    logic last;
  } div_rsp_t;

  // Peak ring control.
  typedef struct packed {
    logic reload;
    logic advance;
  } peak_ctl_t;

endpackage

>>> hw/rtl/ssest_if.sv
// ----------------------------------------------------------------------------
// ssest_if
// Valid/ready channels of the support side estimator: sample in, result out.
// ----------------------------------------------------------------------------
interface ssest_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] left_front_left;
  logic [15:0] left_front_right;
  logic [15:0] left_rear_left;
  logic [15:0] left_rear_right;
  logic [15:0] right_front_left;
  logic [15:0] right_front_right;
  logic [15:0] right_rear_left;
  logic [15:0] right_rear_right;

  modport source (
    output valid, left_front_left, left_front_right, left_rear_left, left_rear_right,
           right_front_left, right_front_right, right_rear_left, right_rear_right,
    input  ready
  );
  modport sink (
    input  valid, left_front_left, left_front_right, left_rear_left, left_rear_right,
           right_front_left, right_front_right, right_rear_left, right_rear_right,
    output ready
  );
endinterface

interface ssest_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] support_side;
  logic               support_changed;

  modport source (output valid, support_side, support_changed, input ready);
  modport sink (input valid, support_side, support_changed, output ready);
endinterface

>>> hw/rtl/ssest_div.sv
// ----------------------------------------------------------------------------
// ssest_div
// Restoring bit-serial divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module ssest_div (
  input  logic                clk,
  input  logic                rst,
  input  ssest_pkg::div_req_t req,
  output ssest_pkg::div_rsp_t rsp
);
  import ssest_pkg::*;

  localparam int CntW = $clog2(QuotW);

  logic              busy;
  logic [CntW-1:0]   cnt;
  logic [TotalW-1:0] rem;
  logic [TotalW-1:0] divisor;
  logic [QuotW-1:0]  low;
  logic [RemW-1:0]   trial;
  logic [RemW:0]     diff;
  logic              fits;
  logic [TotalW-1:0] rem_next;

  // Shift in the next dividend bit and try a subtraction.
  always_comb begin
    trial    = {rem, low[QuotW-1]};
    diff     = {1'b0, trial} - {2'b00, divisor};
    fits     = !diff[RemW];
    rem_next = fits ? diff[TotalW-1:0] : trial[TotalW-1:0];
  end

  // Step control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= CntW'(QuotW - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end
      cnt <= cnt - 1'b1;
    end
  end

  // Remainder and dividend shift register.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= req.rem_init;
      low     <= req.low_bits;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= rem_next;
      low <= {low[QuotW-2:0], 1'b0};
    end
  end

  assign rsp.q_valid = busy;
  assign rsp.q_bit   = fits;
  assign rsp.last    = busy && (cnt == '0);

endmodule

>>> hw/rtl/ssest_peaks.sv
// ----------------------------------------------------------------------------
// ssest_peaks
// Reading clamp and per-sensor peak trackers kept as a rotating ring.
// ----------------------------------------------------------------------------
module ssest_peaks (
  input  logic                                clk,
  input  logic                                rst,
  input  ssest_pkg::peak_ctl_t                ctl,
  input  logic [ssest_pkg::ReadW-1:0]         start_value,
  input  logic [ssest_pkg::ReadW-1:0]         clamp,
  input  logic [ssest_pkg::ReadW-1:0]         reading,
  output logic [ssest_pkg::ReadW-1:0]         clamped,
  output logic [ssest_pkg::ReadW-1:0]         peak_new
);
  import ssest_pkg::*;

  logic [ReadW-1:0] peak [SensorCount];

  // The head of the ring always belongs to the sensor being processed.
  always_comb begin
    clamped  = (reading > clamp) ? clamp : reading;
    peak_new = (clamped > peak[0]) ? clamped : peak[0];
  end

  // Rotate once per sensor, so the ring is back in order after each sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < SensorCount; j++) begin
        peak[j] <= PeakReset;
      end
    end else if (ctl.reload) begin
      for (int j = 0; j < SensorCount; j++) begin
        peak[j] <= start_value;
      end
    end else if (ctl.advance) begin
      for (int j = 0; j < SensorCount - 1; j++) begin
        peak[j] <= peak[j+1];
      end
      peak[SensorCount-1] <= peak_new;
    end
  end

endmodule

>>> hw/rtl/support_side_estimator_unit.sv
// ----------------------------------------------------------------------------
// support_side_estimator_unit
// Support side from eight foot pressure sensors, computed with one shared
// bit-serial divider for the per-sensor fractions and the final quotient.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  samples   in   eight 16-bit pressure readings, left foot first
//  result    out  support_side (Q4.12, signed), support_changed
//  cfg_*     in   write enable, 2-bit register index, 16-bit data
//
// From acceptance to the result register a sample passes, per sensor, a setup
// state, the divider steps and an accumulate state, then a setup state, the
// quotient steps (skipped for a zero total) and a load state.
// Samples are taken one at a time: the next is accepted only back in the idle state.
// A result stalls the next sample only while the result register is still full.
// Synchronous reset restores config, state, result valid, previous side and peaks.
// ----------------------------------------------------------------------------
module support_side_estimator_unit (
  input  logic                            clk,
  input  logic                            rst,
  ssest_in_if.sink                        samples,
  ssest_out_if.source                     result,
  input  logic                            cfg_wr_en,
  input  logic [ssest_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ssest_pkg::CfgDataW-1:0]  cfg_data
);
  import ssest_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_LOAD = 7'b0000010,
    ST_FRAC = 7'b0000100,
    ST_SUM  = 7'b0001000,
    ST_QUOT = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

  localparam logic [IdxW-1:0] HalfIdx = IdxW'(SensorCount / 2);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SensorCount - 1);

  state_t state;
  state_t state_next;

  // Configuration registers.
  logic [ReadW-1:0]   clamp_reg;
  logic [ReadW-1:0]   peak_start;
  logic [WeightW-1:0] outer_w;
  logic [WeightW-1:0] inner_w;

  // Datapath registers.
  logic [ReadW-1:0]       sample [SensorCount];
  logic [IdxW-1:0]        idx;
  logic                   zero_div;
  logic [FracW-1:0]       frac;
  logic [ProdW-1:0]       prod;
  logic [TotalW-1:0]      total;
  logic signed [AccW-1:0] weighted;
  logic                   neg;
  logic [QuotW-1:0]       quot;
  logic signed [15:0]     prev_side;
  logic                   out_valid;
  logic signed [15:0]     out_side;
  logic                   out_changed;

  // Internal nets.
  peak_ctl_t          peak_ctl;
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic [ReadW-1:0]   clamped;
  logic [ReadW-1:0]   peak_new;
  logic               accept;
  logic               is_left;
  logic [IdxW-1:0]    pos;
  logic               is_outer;
  logic [WeightW-1:0] cur_w;
  logic               qb;
  logic [ProdW-1:0]   prod_next;
  logic signed [AccW-1:0] prod_ext;
  logic [AccW-1:0]    mag;
  logic signed [15:0] side_val;
  logic               changed;
  logic               out_free;

  assign accept        = samples.valid && samples.ready;
  assign samples.ready = (state == ST_IDLE);
  assign out_free      = !out_valid || result.ready;

  assign result.valid           = out_valid;
  assign result.support_side    = out_side;
  assign result.support_changed = out_changed;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      clamp_reg  <= ClampReset;
      peak_start <= PeakReset;
      outer_w    <= WeightReset;
      inner_w    <= WeightReset;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_CLAMP:      clamp_reg  <= cfg_data;
        REG_PEAK_START: peak_start <= cfg_data;
        REG_OUTER:      outer_w    <= cfg_data[WeightW-1:0];
        REG_INNER:      inner_w    <= cfg_data[WeightW-1:0];
        default:        clamp_reg  <= clamp_reg;
      endcase
    end
  end

  // Clamp and peak trackers.
  assign peak_ctl.reload  = cfg_wr_en && (cfg_reg_t'(cfg_index) == REG_PEAK_START);
  assign peak_ctl.advance = (state == ST_LOAD);

  ssest_peaks u_peaks (
    .clk         (clk),
    .rst         (rst),
    .ctl         (peak_ctl),
    .start_value (cfg_data),
    .clamp       (clamp_reg),
    .reading     (sample[0]),
    .clamped     (clamped),
    .peak_new    (peak_new)
  );

  // Sensor weight: left foot positive, outer sensors on the foot's outside edge.
  always_comb begin
    is_left  = (idx < HalfIdx);
    pos      = is_left ? idx : idx - HalfIdx;
    is_outer = is_left ? !pos[0] : pos[0];
    cur_w    = is_outer ? outer_w : inner_w;
  end

  // Quotient bits feed the fraction and a shift-add product with the weight.
  always_comb begin
    qb        = div_rsp.q_bit && !zero_div;
    prod_next = {prod[ProdW-2:0], 1'b0} + (qb ? ProdW'(cur_w) : '0);
    prod_ext  = AccW'($signed({1'b0, prod}));
    mag       = weighted[AccW-1] ? AccW'(-weighted) : AccW'(weighted);
  end

  // Divider requests: a fraction per sensor, then the final quotient.
  always_comb begin
    div_req = '0;
    if (state == ST_LOAD) begin
      div_req.start    = 1'b1;
      div_req.rem_init = TotalW'(clamped >> 1);
      div_req.low_bits = {clamped[0], {(QuotW-1){1'b0}}};
      div_req.divisor  = TotalW'(peak_new);
    end else if (state == ST_QUOT && total != '0) begin
      div_req.start    = 1'b1;
      div_req.rem_init = TotalW'(mag[MagW-1:QuotW]);
      div_req.low_bits = mag[QuotW-1:0];
      div_req.divisor  = total;
    end
  end

  ssest_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Result sign and sign-change flag.
  always_comb begin
    side_val = neg ? -$signed(quot) : $signed(quot);
    changed  = (prev_side < 0 && side_val > 0) || (prev_side > 0 && side_val < 0);
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_LOAD;
      ST_LOAD: state_next = ST_FRAC;
      ST_FRAC: if (div_rsp.last) state_next = ST_SUM;
      ST_SUM:  state_next = (idx == LastIdx) ? ST_QUOT : ST_LOAD;
      ST_QUOT: state_next = (total == '0) ? ST_FIN : ST_DIV;
      ST_DIV:  if (div_rsp.last) state_next = ST_FIN;
      ST_FIN:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sample capture, then shift one reading out per sensor.
  always_ff @(posedge clk) begin
    if (accept) begin
      sample[0] <= samples.left_front_left;
      sample[1] <= samples.left_front_right;
      sample[2] <= samples.left_rear_left;
      sample[3] <= samples.left_rear_right;
      sample[4] <= samples.right_front_left;
      sample[5] <= samples.right_front_right;
      sample[6] <= samples.right_rear_left;
      sample[7] <= samples.right_rear_right;
    end else if (state == ST_LOAD) begin
      for (int j = 0; j < SensorCount - 1; j++) begin
        sample[j] <= sample[j+1];
      end
    end
  end

  // Accumulators and quotient shift register.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        idx      <= '0;
        total    <= '0;
        weighted <= '0;
      end
      ST_LOAD: begin
        zero_div <= (peak_new == '0);
        frac     <= '0;
        prod     <= '0;
      end
      ST_FRAC: begin
        if (div_rsp.q_valid) begin
          frac <= {frac[FracW-2:0], qb};
          prod <= prod_next;
        end
      end
      ST_SUM: begin
        total    <= total + TotalW'(frac);
        weighted <= is_left ? weighted + prod_ext : weighted - prod_ext;
        idx      <= idx + 1'b1;
      end
      ST_QUOT: begin
        quot <= '0;
        neg  <= (total != '0) && weighted[AccW-1];
      end
      ST_DIV: begin
        if (div_rsp.q_valid) begin
          quot <= {quot[QuotW-2:0], div_rsp.q_bit};
        end
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

  // Result register and previous side.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      prev_side <= '0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
      prev_side <= side_val;
    end else if (out_valid && result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      out_side    <= side_val;
      out_changed <= changed;
    end
  end

endmodule

>>> hw/rtl/ssest_checker.sv
// ----------------------------------------------------------------------------
// ssest_checker
// Port-level checks of the support side estimator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssest_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] support_side,
  input logic        support_changed
);

  // A stalled result beat keeps its contents.
  `SSEST_ASSERT_NEXT(a_out_hold,
    out_valid && !out_ready,
    out_valid && $stable(support_side) && $stable(support_changed),
    "stalled result beat changed")

  // A sign change can only be reported for a nonzero side.
  `SSEST_ASSERT_IMPL(a_changed_nonzero,
    out_valid && support_changed,
    support_side != 16'h0000,
    "support_changed set with zero side")

  // The quotient magnitude never exceeds the largest weight.
  `SSEST_ASSERT_IMPL(a_side_range,
    out_valid,
    support_side != 16'h8000,
    "support_side out of range")

  // One sample at a time: input is closed in the cycle after a beat is taken.
  `SSEST_ASSERT_NEXT(a_one_at_a_time,
    in_valid && in_ready,
    !in_ready,
    "second sample taken while busy")

endmodule

bind support_side_estimator_unit ssest_checker u_ssest_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (samples.valid),
  .in_ready        (samples.ready),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .support_side    (result.support_side),
  .support_changed (result.support_changed)
);

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the support side estimator. Eight-sensor pressure
// samples go in over a valid/ready channel with random gaps. The result
// channel stalls at random. A scoreboard keeps its own peak trackers and
// register copies, predicts each side estimate and sign-flip flag, and checks
// every result beat in order. Directed samples hit the arithmetic corners and
// special cases, and random phases then sweep several register settings.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssest_pkg::*;

  localparam int HalfPeriod  = 6;
  localparam int WatchLimit  = 4000;
  localparam int SettleCycles = 200;
  localparam int ItemsPerPhase = 100;
  localparam int MaxReports  = 10;

  typedef logic [ReadW-1:0] reading_set_t [SensorCount];

  // Scoreboard: mirrors the registers and peak trackers, and predicts results.
  class side_scoreboard;
    typedef struct {
      logic signed [QuotW-1:0] side;
      logic                    changed;
    } side_result_t;

    logic [ReadW-1:0]   clamp;
    logic [ReadW-1:0]   peak_start;
    logic [WeightW-1:0] w_outer;
    logic [WeightW-1:0] w_inner;
    logic [ReadW-1:0]   peak [SensorCount];
    int                 prev_side;
    side_result_t       side_q[$];
    int                 errors;
    int                 checked;
    int                 flips;
    int                 zero_totals;

    function new();
      clamp      = ClampReset;
      peak_start = PeakReset;
      w_outer    = WeightReset;
      w_inner    = WeightReset;
      foreach (peak[i]) peak[i] = PeakReset;
      prev_side  = 0;
      errors     = 0;
      checked    = 0;
      flips      = 0;
      zero_totals = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_CLAMP: begin
          clamp = data;
        end
        REG_PEAK_START: begin
          peak_start = data;
          foreach (peak[i]) peak[i] = data;
        end
        REG_OUTER: begin
          w_outer = data[WeightW-1:0];
        end
        REG_INNER: begin
          w_inner = data[WeightW-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    // Predict the result of one accepted sample and update the tracker state.
    function void note_sample(reading_set_t r);
      longint       total;
      longint       weighted;
      longint       frac;
      longint       w;
      logic [ReadW-1:0] p;
      int           pos;
      bit           outer;
      int           side;
      bit           changed;
      side_result_t e;
      total = 0;
      weighted = 0;
      side = 0;
      changed = 0;
      for (int i = 0; i < SensorCount; i++) begin
        p = (r[i] > clamp) ? clamp : r[i];
        if (p > peak[i]) peak[i] = p;
        frac = (peak[i] != 0) ? ((longint'(p) << 15) / longint'(peak[i])) : 0;
        // Left foot: even positions are outer. Right foot: odd positions are outer.
        pos = i % (SensorCount / 2);
        outer = (i < SensorCount / 2) ? (pos % 2 == 0) : (pos % 2 == 1);
        w = outer ? longint'(w_outer) : longint'(w_inner);
        if (i >= SensorCount / 2) w = -w;
        total += frac;
        weighted += w * frac;
      end
      if (total > 0) begin
        side = int'(weighted / total);
        changed = (prev_side < 0 && side > 0) || (prev_side > 0 && side < 0);
      end else begin
        zero_totals++;
      end
      prev_side = side;
      if (changed) flips++;
      e.side = side[QuotW-1:0];
      e.changed = changed;
      side_q.push_back(e);
    endfunction

    function void report(string what, int exp_val, int act_val);
      errors++;
      if (errors <= MaxReports)
        $display("MISMATCH %s: expected %0d, got %0d (beat %0d)",
                 what, exp_val, act_val, checked);
    endfunction

    // Check one result beat against the oldest prediction.
    function void check_result(logic signed [QuotW-1:0] side, logic changed);
      side_result_t e;
      if (side_q.size() == 0) begin
        report("unexpected result beat, support_side", 0, int'(side));
        return;
      end
      e = side_q.pop_front();
      checked++;
      if (side !== e.side) report("support_side", int'(e.side), int'(side));
      if (changed !== e.changed) report("support_changed", int'(e.changed), int'(changed));
    endfunction

    function int pending();
      return side_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic                cfg_wr_en;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  ssest_in_if  samples_if ();
  ssest_out_if result_if ();

  support_side_estimator_unit uut (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples_if),
    .result    (result_if),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  side_scoreboard board;
  bit calm;
  int samples_sent;
  int settings_used;
  int idle_cycles;

  always #(HalfPeriod) clk = ~clk;

  // Random gap length: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 250);
  endfunction

  function automatic logic [ReadW-1:0] rand_reading(int scale);
    case (scale)
      0: return ReadW'($urandom_range(0, 65535));
      1: return ReadW'($urandom_range(0, 1023));
      2: return ReadW'($urandom_range(0, 31));
      default: return '0;
    endcase
  endfunction

  // Same reading on front and rear of each role: left outer/inner, right inner/outer.
  function automatic reading_set_t pair_sample(logic [ReadW-1:0] lo, logic [ReadW-1:0] li,
                                               logic [ReadW-1:0] ri, logic [ReadW-1:0] ro);
    reading_set_t r;
    r[0] = lo; r[1] = li; r[2] = lo; r[3] = li;
    r[4] = ri; r[5] = ro; r[6] = ri; r[7] = ro;
    return r;
  endfunction

  // Random sample: mostly one foot loaded so the side flips often, some noise.
  function automatic reading_set_t rand_sample();
    reading_set_t r;
    int mode;
    int ls;
    int rs;
    mode = $urandom_range(0, 19);
    ls = $urandom_range(0, 2);
    rs = $urandom_range(0, 2);
    foreach (r[i]) r[i] = '0;
    if (mode == 0) return r;
    for (int i = 0; i < SensorCount; i++) begin
      if (mode <= 6)
        r[i] = (i < SensorCount / 2) ? rand_reading(ls) : rand_reading($urandom_range(2, 3));
      else if (mode <= 12)
        r[i] = (i < SensorCount / 2) ? rand_reading($urandom_range(2, 3)) : rand_reading(rs);
      else
        r[i] = rand_reading($urandom_range(0, 2));
    end
    return r;
  endfunction

  // Offer one sample beat after a gap; returns at the falling edge after acceptance.
  task automatic send_sample(reading_set_t s);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      samples_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    samples_if.left_front_left   = s[0];
    samples_if.left_front_right  = s[1];
    samples_if.left_rear_left    = s[2];
    samples_if.left_rear_right   = s[3];
    samples_if.right_front_left  = s[4];
    samples_if.right_front_right = s[5];
    samples_if.right_rear_left   = s[6];
    samples_if.right_rear_right  = s[7];
    samples_if.valid = 1'b1;
    do @(posedge clk); while (!samples_if.ready);
    board.note_sample(s);
    samples_sent++;
    @(negedge clk);
  endtask

  // Wait until the block is idle, then write all four registers.
  task automatic set_regs(logic [CfgDataW-1:0] clamp_v, logic [CfgDataW-1:0] start_v,
                          logic [CfgDataW-1:0] outer_v, logic [CfgDataW-1:0] inner_v);
    cfg_reg_t idx [4];
    logic [CfgDataW-1:0] val [4];
    idx = '{REG_CLAMP, REG_PEAK_START, REG_OUTER, REG_INNER};
    val = '{clamp_v, start_v, outer_v, inner_v};
    samples_if.valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en = 1'b1;
      cfg_index = idx[i];
      cfg_data  = val[i];
      board.write_reg(idx[i], val[i]);
      @(negedge clk);
    end
    cfg_wr_en = 1'b0;
    settings_used++;
  endtask

  // Result side ready: random stalls, none while calm.
  initial begin
    int stall_left;
    stall_left = 0;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        result_if.ready = 1'b0;
        stall_left--;
      end else begin
        result_if.ready = 1'b1;
        stall_left = gap_len();
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready)
      board.check_result(result_if.support_side, result_if.support_changed);
  end

  // Watchdog on cycles with no beat on either channel.
  always @(posedge clk) begin
    if (rst || (samples_if.valid && samples_if.ready) || (result_if.valid && result_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("watchdog: no beat for %0d cycles, %0d results still pending",
               idle_cycles, board.pending());
      $display("simulation failed");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    logic [CfgDataW-1:0] phase_cfg [6][4];
    reading_set_t s;
    board = new();
    rst = 1'b1;
    calm = 1'b0;
    samples_sent = 0;
    settings_used = 1;
    cfg_wr_en = 1'b0;
    cfg_index = REG_CLAMP;
    cfg_data = '0;
    samples_if.valid = 1'b0;
    samples_if.left_front_left   = '0;
    samples_if.left_front_right  = '0;
    samples_if.left_rear_left    = '0;
    samples_if.left_rear_right   = '0;
    samples_if.right_front_left  = '0;
    samples_if.right_front_right = '0;
    samples_if.right_rear_left   = '0;
    samples_if.right_rear_right  = '0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Directed, reset settings: zero total, readings under the start peak,
    // balanced full load, single roles on each foot and sign flips.
    send_sample(pair_sample(0, 0, 0, 0));
    send_sample(pair_sample(205, 100, 0, 0));
    send_sample(pair_sample(0, 0, 300, 410));
    send_sample(pair_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_sample(pair_sample(16'hFFFF, 0, 0, 0));
    send_sample(pair_sample(0, 0, 0, 16'hFFFF));
    send_sample(pair_sample(0, 0, 0, 0));
    send_sample(pair_sample(0, 16'hFFFF, 0, 0));
    for (int i = 0; i < SensorCount; i++) s[i] = 16'h1 << (2 * i);
    send_sample(s);
    for (int i = 0; i < SensorCount; i++) s[i] = 16'hAAAA >> i;
    send_sample(s);

    // Smallest nonzero clamp and start, largest outer weight, zero inner weight.
    set_regs(16'd1, 16'd1, 16'd32767, 16'd0);
    send_sample(pair_sample(16'hFFFF, 16'hFFFF, 0, 0));
    send_sample(pair_sample(0, 0, 1, 1));
    send_sample(pair_sample(0, 1, 0, 0));
    send_sample(pair_sample(1, 0, 0, 0));
    send_sample(pair_sample(0, 0, 0, 1));

    // A zero clamp forces every reading, and so the total, to zero.
    set_regs(16'd0, 16'd410, 16'd4096, 16'd32767);
    send_sample(pair_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_sample(pair_sample(16'h8000, 1, 0, 16'h7FFF));

    // A zero start peak: sensors left at zero give a zero fraction.
    set_regs(16'hFFFF, 16'd0, 16'd4096, 16'd32767);
    send_sample(pair_sample(0, 0, 0, 0));
    send_sample(pair_sample(0, 100, 0, 0));
    send_sample(pair_sample(0, 0, 7, 0));
    send_sample(pair_sample(0, 50, 3, 0));

    // Random phases, each with its own settings and fresh peaks.
    phase_cfg[0] = '{16'hFFFF, 16'd410, 16'd4096, 16'd4096};
    phase_cfg[1] = '{16'hFFFF, 16'hFFFF, 16'd32767, 16'd32767};
    phase_cfg[2] = '{16'd1000, 16'd1, 16'd32767, 16'd0};
    phase_cfg[3] = '{16'hFFFF, 16'd2000, 16'd0, 16'd32767};
    phase_cfg[4] = '{16'd200, 16'd50, 16'd12345, 16'd3000};
    phase_cfg[5] = '{CfgDataW'($urandom_range(1, 65535)), CfgDataW'($urandom_range(1, 65535)),
                     CfgDataW'($urandom_range(0, 32767)), CfgDataW'($urandom_range(0, 32767))};
    for (int p = 0; p < 6; p++) begin
      set_regs(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3]);
      calm = (p % 3 == 2);
      for (int n = 0; n < ItemsPerPhase; n++) send_sample(rand_sample());
    end
    samples_if.valid = 1'b0;
    calm = 1'b0;

    // Drain, then let the pipeline settle to catch stray result beats.
    while (board.pending() != 0) @(negedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("%0d samples over %0d register settings, %0d results checked",
             samples_sent, settings_used, board.checked);
    $display("%0d support side flips and %0d zero-total samples predicted, %0d mismatches",
             board.flips, board.zero_totals, board.errors);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
